// ----- sv/clfp_pkg.sv -----
package clfp_pkg;

  localparam int CELLS = 16;
  localparam int IDXW = 4;
  localparam logic [4:0] NIL = 5'h1F;
  localparam int QDEPTH = 2;

  typedef enum logic [1:0] {
    CMD_FRONT   = 2'd0,
    CMD_TAIL    = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  // One classified command handed from the front part to the back part.
  typedef struct packed {
    cmd_t       cmd;
    logic       rel_ok;
    logic [31:0] value;
    logic [IDXW-1:0] idx;
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TAKE,
    ST_WALK,
    ST_LINK,
    ST_DONE
  } state_t;

  // A link is a real cell when its sign bit is clear and it lies below CELLS.
  function automatic logic valid_link(input logic [4:0] l);
    return (l[4] == 1'b0) && ({1'b0, l} < 6'(CELLS));
  endfunction

endpackage

// ----- sv/clfp_front.sv -----
module clfp_front
  import clfp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              valid,
  output logic              stall,
  input  logic [1:0]        command,
  input  logic signed [31:0] value,
  input  logic [3:0]        cell_index,
  output logic              q_valid,
  output op_t               q_op,
  input  logic              q_pop
);

  op_t              slots [QDEPTH];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push;
  op_t              op_in;

  // Classify the incoming item.
  always_comb begin
    op_in.cmd    = cmd_t'(command);
    op_in.rel_ok = ({1'b0, cell_index} < 5'(CELLS));
    op_in.value  = value;
    op_in.idx    = cell_index;
  end

  assign stall   = (count == 2'(QDEPTH));
  assign push    = valid && !stall;
  assign q_valid = (count != 2'd0);
  assign q_op    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= op_in;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("pop from empty queue");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (count == 2'(QDEPTH) && !q_pop) |=> count == 2'(QDEPTH))
    else $error("queue count lost");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= 2'(QDEPTH))
    else $error("queue count overflow");

endmodule

// ----- sv/clfp_back.sv -----
module clfp_back
  import clfp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  op_t               q_op,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              status,
  output logic signed [4:0] new_cell,
  output logic signed [4:0] head_now,
  output logic signed [4:0] free_now
);

  logic [31:0]     cell_values [CELLS];
  logic [4:0]      links [CELLS];
  logic [CELLS-1:0] link_set;
  logic [4:0]      list_head;
  logic [4:0]      free_head;
  state_t          state;
  state_t          state_next;
  op_t             op;
  logic [4:0]      got;
  logic [4:0]      at;
  logic [IDXW:0]   hops;
  logic [4:0]      rd_link;
  logic [4:0]      nxt;
  logic [IDXW-1:0] rd_addr;

  // Link read: entries never written since reset hold their initial chain.
  always_comb begin
    rd_addr = (state == ST_TAKE) ? free_head[IDXW-1:0] : at[IDXW-1:0];
    rd_link = link_set[rd_addr] ? links[rd_addr] :
              ((32'(rd_addr) == CELLS - 1) ? NIL : 5'(rd_addr) + 5'd1);
    nxt     = (at == NIL) ? list_head : rd_link;
  end

  // Sequencer for one command.
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    unique case (state)
      ST_IDLE: if (q_valid) begin
        q_pop = 1'b1;
        state_next = ST_TAKE;
      end
      ST_TAKE: begin
        if (op.cmd == CMD_TAIL && valid_link(free_head)) state_next = ST_WALK;
        else state_next = ST_DONE;
      end
      ST_WALK: begin
        if (!valid_link(nxt) || 32'(hops) == CELLS - 1) state_next = ST_LINK;
      end
      ST_LINK: state_next = ST_DONE;
      ST_DONE: if (!out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  assign out_valid = (state == ST_DONE);

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      list_head <= NIL;
      free_head <= 5'd0;
      link_set  <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          op   <= q_op;
          got  <= NIL;
          at   <= NIL;
          hops <= '0;
        end
        ST_TAKE: begin
          status <= 1'b0;
          if (op.cmd == CMD_FRONT || op.cmd == CMD_TAIL) begin
            if (!valid_link(free_head)) begin
              status <= 1'b1;
            end else begin
              got <= free_head;
              free_head <= rd_link;
              cell_values[free_head[IDXW-1:0]] <= op.value;
              link_set[free_head[IDXW-1:0]] <= 1'b1;
              if (op.cmd == CMD_FRONT) begin
                links[free_head[IDXW-1:0]] <= list_head;
                list_head <= free_head;
              end else begin
                links[free_head[IDXW-1:0]] <= NIL;
              end
            end
          end else if (op.cmd == CMD_RELEASE && op.rel_ok) begin
            links[op.idx] <= free_head;
            link_set[op.idx] <= 1'b1;
            free_head <= {1'b0, op.idx};
          end
        end
        ST_WALK: begin
          if (valid_link(nxt)) at <= nxt;
          hops <= hops + 1'b1;
        end
        ST_LINK: begin
          if (at == NIL) begin
            list_head <= got;
          end else begin
            links[at[IDXW-1:0]] <= got;
            link_set[at[IDXW-1:0]] <= 1'b1;
          end
        end
        ST_DONE: ;
        default: ;
      endcase
    end
  end

  assign new_cell = got;
  assign head_now = list_head;
  assign free_now = free_head;

  a_full_nocell: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> new_cell == NIL)
    else $error("full result carries a cell");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(free_now))
    else $error("result changed under stall");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> state == ST_IDLE)
    else $error("pop outside idle");

endmodule

// ----- sv/cursor_list_free_pool.sv -----
// Cursor list with a free pool of 16 cells.
// Input channel: valid/stall with command, value and cell_index. Command 0
// inserts at the front, 1 inserts at the tail, 2 releases a cell back to
// the free chain. Output channel: valid/stall with status, new_cell,
// head_now and free_now, one result item per input item.
// A two-entry queue decouples command intake from the execution sequencer.
// Front insert, release and unused commands pass from IDLE through TAKE to
// DONE; a tail insert also walks the links one memory read a cycle in WALK
// and then writes the new link in LINK before DONE.
// The sequencer handles one item at a time: it pops no new item from the
// queue until the current result has been taken in DONE.
// Reset clears the list to empty and the free chain to 0,1,...,CELLS-1,
// with no clearing pass. While the output is stalled the result holds and
// the sequencer waits; the queue keeps accepting until it is full.
module cursor_list_free_pool
  import clfp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        command,
  input  logic signed [31:0] value,
  input  logic [3:0]        cell_index,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              status,
  output logic signed [4:0] new_cell,
  output logic signed [4:0] head_now,
  output logic signed [4:0] free_now
);

  logic q_valid;
  logic q_pop;
  op_t  q_op;

  clfp_front u_front (
    .clk, .rst, .valid(in_valid), .stall(in_stall), .command, .value, .cell_index,
    .q_valid, .q_op, .q_pop
  );

  clfp_back u_back (
    .clk, .rst, .q_valid, .q_op, .q_pop, .out_valid, .out_stall,
    .status, .new_cell, .head_now, .free_now
  );

endmodule
